@@ rtl/ordered_list_engine_defines.svh @@
// Assertion macros used by the ordered list engine sequencer.
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS

`define OLE_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("ordered list engine check failed");

`define OLE_ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("ordered list engine forbidden condition");

`else

`define OLE_ASSERT(lbl, clk, rstn, prop)

`define OLE_ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

@@ rtl/ole_pkg.sv @@
// Package with constants, codes and types of the ordered list engine.
`default_nettype none

package ole_pkg;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = 64;

  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_FIND   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [DW-1:0] read_word;
    logic [AW-1:0] match_index;
    logic          match_found;
    logic [CW-1:0] length;
    logic [1:0]    status;
  } res_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    logic [DW-1:0] data;
  } ram_wr_t;

endpackage

`default_nettype wire

@@ rtl/ole_ram.sv @@
// Entry store: one write port, one registered read port.
`default_nettype none

module ole_ram (
  input  wire                            clk_i,
  input  wire ole_pkg::ram_wr_t          wr_i,
  input  wire logic [ole_pkg::AW-1:0]    raddr_i,
  output logic      [ole_pkg::DW-1:0]    rdata_o
);

  logic [ole_pkg::DW-1:0] mem [ole_pkg::DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/ole_seq.sv @@
// Sequencer: decodes a request and walks the entry store one entry a cycle.
`default_nettype none
`include "ordered_list_engine_defines.svh"

module ole_seq (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             command_i,
  input  wire logic [ole_pkg::AW-1:0] position_i,
  input  wire logic [ole_pkg::DW-1:0] data_word_i,
  input  wire                         out_free_i,
  output logic                        done_o,
  output ole_pkg::res_t               res_o,
  output ole_pkg::ram_wr_t            ram_wr_o,
  output logic [ole_pkg::AW-1:0]      ram_raddr_o,
  input  wire logic [ole_pkg::DW-1:0] ram_rdata_i
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DISP  = 7'b0000010,
    S_RWAIT = 7'b0000100,
    S_UP    = 7'b0001000,
    S_DN    = 7'b0010000,
    S_FIND  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  state_e                 state_q, state_d;
  logic [ole_pkg::CW-1:0] count_q, count_d;
  logic [ole_pkg::CW-1:0] idx_q, idx_d;
  logic [ole_pkg::AW-1:0] waddr_q, waddr_d;
  logic                   wpend_q, wpend_d;
  logic                   cvalid_q, cvalid_d;
  logic [ole_pkg::AW-1:0] cidx_q, cidx_d;
  logic [1:0]             cmd_q, cmd_d;
  logic [ole_pkg::AW-1:0] pos_q, pos_d;
  logic [ole_pkg::DW-1:0] word_q, word_d;
  logic [ole_pkg::DW-1:0] rd_q, rd_d;
  logic [ole_pkg::AW-1:0] midx_q, midx_d;
  logic                   mfound_q, mfound_d;
  logic [1:0]             status_q, status_d;
  logic [ole_pkg::CW-1:0] pos_ext;
  logic [ole_pkg::CW-1:0] idx_m1;
  logic [ole_pkg::CW-1:0] idx_p1;
  logic                   word_eq;

  assign pos_ext = {1'b0, pos_q};
  assign idx_m1  = idx_q - 1'b1;
  assign idx_p1  = idx_q + 1'b1;
  assign word_eq = (ram_rdata_i == word_q);

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    waddr_d     = waddr_q;
    wpend_d     = wpend_q;
    cvalid_d    = 1'b0;
    cidx_d      = cidx_q;
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    word_d      = word_q;
    rd_d        = rd_q;
    midx_d      = midx_q;
    mfound_d    = mfound_q;
    status_d    = status_q;
    ram_raddr_o = pos_q;
    ram_wr_o.we   = 1'b0;
    ram_wr_o.addr = waddr_q;
    ram_wr_o.data = ram_rdata_i;
    done_o      = 1'b0;
    in_ready_o  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d   = command_i;
          pos_d   = position_i;
          word_d  = data_word_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        rd_d     = '0;
        midx_d   = '0;
        mfound_d = 1'b0;
        status_d = ole_pkg::ST_OK;
        wpend_d  = 1'b0;
        unique case (cmd_q)
          ole_pkg::CMD_READ: begin
            state_d = (pos_ext < count_q) ? S_RWAIT : S_DONE;
          end
          ole_pkg::CMD_INSERT: begin
            if (count_q == ole_pkg::CW'(ole_pkg::DEPTH)) begin
              status_d = ole_pkg::ST_FULL;
              state_d  = S_DONE;
            end else if (pos_ext > count_q) begin
              status_d = ole_pkg::ST_RANGE;
              state_d  = S_DONE;
            end else begin
              idx_d   = count_q;
              state_d = S_UP;
            end
          end
          ole_pkg::CMD_REMOVE: begin
            if (pos_ext >= count_q) begin
              status_d = ole_pkg::ST_RANGE;
              state_d  = S_DONE;
            end else begin
              idx_d   = pos_ext;
              state_d = S_DN;
            end
          end
          default: begin
            idx_d   = '0;
            state_d = S_FIND;
          end
        endcase
      end
      S_RWAIT: begin
        rd_d    = ram_rdata_i;
        state_d = S_DONE;
      end
      S_UP: begin
        ram_wr_o.we = wpend_q;
        if (idx_q != pos_ext) begin
          ram_raddr_o = idx_m1[ole_pkg::AW-1:0];
          wpend_d     = 1'b1;
          waddr_d     = idx_q[ole_pkg::AW-1:0];
          idx_d       = idx_m1;
        end else if (wpend_q) begin
          wpend_d = 1'b0;
        end else begin
          ram_wr_o.we   = 1'b1;
          ram_wr_o.addr = pos_q;
          ram_wr_o.data = word_q;
          count_d       = count_q + 1'b1;
          state_d       = S_DONE;
        end
      end
      S_DN: begin
        ram_wr_o.we = wpend_q;
        if (idx_p1 < count_q) begin
          ram_raddr_o = idx_p1[ole_pkg::AW-1:0];
          wpend_d     = 1'b1;
          waddr_d     = idx_q[ole_pkg::AW-1:0];
          idx_d       = idx_p1;
        end else if (wpend_q) begin
          wpend_d = 1'b0;
        end else begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end
      S_FIND: begin
        if (cvalid_q && word_eq) begin
          midx_d   = cidx_q;
          mfound_d = 1'b1;
        end
        if (idx_q < count_q) begin
          ram_raddr_o = idx_q[ole_pkg::AW-1:0];
          cvalid_d    = 1'b1;
          cidx_d      = idx_q[ole_pkg::AW-1:0];
          idx_d       = idx_p1;
        end else if (!cvalid_q) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      wpend_q  <= 1'b0;
      cvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      wpend_q  <= wpend_d;
      cvalid_q <= cvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    waddr_q  <= waddr_d;
    cidx_q   <= cidx_d;
    cmd_q    <= cmd_d;
    pos_q    <= pos_d;
    word_q   <= word_d;
    rd_q     <= rd_d;
    midx_q   <= midx_d;
    mfound_q <= mfound_d;
    status_q <= status_d;
  end

  assign res_o.read_word   = rd_q;
  assign res_o.match_index = midx_q;
  assign res_o.match_found = mfound_q;
  assign res_o.length      = count_q;
  assign res_o.status      = status_q;

  `OLE_ASSERT_NEVER(a_count_max, clk_i, rst_ni, count_q > ole_pkg::CW'(ole_pkg::DEPTH))
  `OLE_ASSERT(a_done_idle, clk_i, rst_ni, done_o |=> state_q == S_IDLE)
  `OLE_ASSERT(a_count_shift, clk_i, rst_ni, (count_q != $past(count_q)) |-> ($past(state_q) == S_UP || $past(state_q) == S_DN))
  `OLE_ASSERT_NEVER(a_no_write_idle, clk_i, rst_ni, ram_wr_o.we && (state_q == S_IDLE || state_q == S_FIND || state_q == S_DONE))

endmodule

`default_nettype wire

@@ rtl/ordered_list_engine.sv @@
// Ordered list engine: sequencer, entry store and result register.
// A read fetches one word and a find scans every stored word; an insert moves the words
// from position up one place, a remove those above position down one place; the store
// gives one entry per cycle. One request at a time; the sequencer is ready for the next
// in the same cycle the result turns valid; a held result stalls. rst_ni clears count
// and control; stored words stay undefined until written.
`default_nettype none

module ordered_list_engine (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             command_i,
  input  wire logic [5:0]             position_i,
  input  wire logic [63:0]            data_word_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [63:0]                 read_word_o,
  output logic [5:0]                  match_index_o,
  output logic                        match_found_o,
  output logic [6:0]                  length_o,
  output logic [1:0]                  status_o
);

  ole_pkg::res_t          res;
  ole_pkg::res_t          out_q;
  ole_pkg::ram_wr_t       ram_wr;
  logic [ole_pkg::AW-1:0] ram_raddr;
  logic [ole_pkg::DW-1:0] ram_rdata;
  logic                   done;
  logic                   out_free;
  logic                   out_valid_q;

  assign out_free = !out_valid_q || out_ready_i;

  ole_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .command_i   (command_i),
    .position_i  (position_i),
    .data_word_i (data_word_i),
    .out_free_i  (out_free),
    .done_o      (done),
    .res_o       (res),
    .ram_wr_o    (ram_wr),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ole_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_word_o   = out_q.read_word;
  assign match_index_o = out_q.match_index;
  assign match_found_o = out_q.match_found;
  assign length_o      = out_q.length;
  assign status_o      = out_q.status;

endmodule

`default_nettype wire

@@ verif/ordered_list_engine_tb.sv @@
// Self-checking testbench for the ordered list engine: a shadow list predicts each result word.
`default_nettype none

module ordered_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RX_HOLD = 400;
  localparam int unsigned PHASE_ITEMS = 500;

  class list_shadow;
    logic [ole_pkg::DW-1:0] words [ole_pkg::DEPTH];
    int unsigned   held;
    ole_pkg::res_t pending[$];
    int unsigned   errors;
    int unsigned   checked;
    int unsigned   requests;
    int unsigned   max_held;
    int unsigned   find_hits;
    int unsigned   per_cmd [4];
    int unsigned   per_status [3];

    function new();
      foreach (words[i]) words[i] = '0;
      held = 0;
      errors = 0;
      checked = 0;
      requests = 0;
      max_held = 0;
      find_hits = 0;
      foreach (per_cmd[i]) per_cmd[i] = 0;
      foreach (per_status[i]) per_status[i] = 0;
    endfunction

    function void note_request(logic [1:0] cmd, logic [ole_pkg::AW-1:0] pos,
                               logic [ole_pkg::DW-1:0] data);
      ole_pkg::res_t r;
      r = '0;
      case (cmd)
        ole_pkg::CMD_READ: begin
          if (pos < held) r.read_word = words[pos];
        end
        ole_pkg::CMD_INSERT: begin
          if (held >= ole_pkg::DEPTH) begin
            r.status = ole_pkg::ST_FULL;
          end else if (pos > held) begin
            r.status = ole_pkg::ST_RANGE;
          end else begin
            for (int i = held; i > pos; i--) words[i] = words[i-1];
            words[pos] = data;
            held++;
          end
        end
        ole_pkg::CMD_REMOVE: begin
          if (pos >= held) begin
            r.status = ole_pkg::ST_RANGE;
          end else begin
            for (int i = pos; i + 1 < held; i++) words[i] = words[i+1];
            held--;
          end
        end
        default: begin
          for (int i = 0; i < held; i++) begin
            if (words[i] === data) begin
              r.match_index = i[ole_pkg::AW-1:0];
              r.match_found = 1'b1;
            end
          end
        end
      endcase
      r.length = held[ole_pkg::CW-1:0];
      requests++;
      per_cmd[cmd]++;
      per_status[r.status]++;
      if (r.match_found) find_hits++;
      if (held > max_held) max_held = held;
      pending.push_back(r);
    endfunction

    function void check_response(ole_pkg::res_t got);
      ole_pkg::res_t exp;
      if (pending.size() == 0) begin
        $error("result word with nothing pending");
        errors++;
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got.read_word !== exp.read_word) begin
        $error("read_word expected %h got %h", exp.read_word, got.read_word);
        errors++;
      end
      if (got.match_index !== exp.match_index) begin
        $error("match_index expected %0d got %0d", exp.match_index, got.match_index);
        errors++;
      end
      if (got.match_found !== exp.match_found) begin
        $error("match_found expected %0d got %0d", exp.match_found, got.match_found);
        errors++;
      end
      if (got.length !== exp.length) begin
        $error("length expected %0d got %0d", exp.length, got.length);
        errors++;
      end
      if (got.status !== exp.status) begin
        $error("status expected %0d got %0d", exp.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [1:0]             command_i = ole_pkg::CMD_READ;
  logic [ole_pkg::AW-1:0] position_i = '0;
  logic [ole_pkg::DW-1:0] data_word_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [ole_pkg::DW-1:0] read_word_o;
  logic [ole_pkg::AW-1:0] match_index_o;
  logic                   match_found_o;
  logic [ole_pkg::CW-1:0] length_o;
  logic [1:0]             status_o;

  list_shadow shadow;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req = 1'b0;

  ordered_list_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .command_i     (command_i),
    .position_i    (position_i),
    .data_word_i   (data_word_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .read_word_o   (read_word_o),
    .match_index_o (match_index_o),
    .match_found_o (match_found_o),
    .length_o      (length_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = RX_HOLD;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      shadow.check_response({read_word_o, match_index_o, match_found_o, length_o, status_o});
    end
  end

  function automatic logic [ole_pkg::DW-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2, 3: return {32'($urandom_range(1)), 32'($urandom_range(3))};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic void random_request(input int unsigned mode, output logic [1:0] cmd,
                                         output logic [ole_pkg::AW-1:0] pos,
                                         output logic [ole_pkg::DW-1:0] data);
    int unsigned roll;
    int unsigned ins_w;
    int unsigned rem_w;
    int unsigned top;
    roll  = $urandom_range(99);
    ins_w = (mode == 0) ? 55 : (mode == 1) ? 15 : 30;
    rem_w = (mode == 0) ? 15 : (mode == 1) ? 45 : 30;
    if (roll < ins_w) cmd = ole_pkg::CMD_INSERT;
    else if (roll < ins_w + rem_w) cmd = ole_pkg::CMD_REMOVE;
    else if (roll < ins_w + rem_w + 15) cmd = ole_pkg::CMD_READ;
    else cmd = ole_pkg::CMD_FIND;
    top = (cmd == ole_pkg::CMD_INSERT) ? shadow.held : shadow.held - 1;
    if (top > ole_pkg::DEPTH - 1) top = ole_pkg::DEPTH - 1;
    if (shadow.held == 0 || $urandom_range(99) < 15)
      pos = ole_pkg::AW'($urandom_range(ole_pkg::DEPTH - 1));
    else
      pos = ole_pkg::AW'($urandom_range(top));
    if (cmd == ole_pkg::CMD_FIND && shadow.held > 0 && $urandom_range(99) < 60)
      data = shadow.words[$urandom_range(shadow.held - 1)];
    else
      data = pick_word();
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [ole_pkg::AW-1:0] pos,
                              input logic [ole_pkg::DW-1:0] data);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    position_i  <= pos;
    data_word_i <= data;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.note_request(cmd, pos, data);
  endtask

  initial begin
    logic [1:0]             cmd;
    logic [ole_pkg::AW-1:0] pos;
    logic [ole_pkg::DW-1:0] data;
    shadow = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list corners
    send_request(ole_pkg::CMD_READ, '0, '0);
    send_request(ole_pkg::CMD_REMOVE, '0, '0);
    send_request(ole_pkg::CMD_FIND, '0, '0);
    send_request(ole_pkg::CMD_INSERT, ole_pkg::AW'(1), '1);
    send_request(ole_pkg::CMD_INSERT, ole_pkg::AW'(ole_pkg::DEPTH - 1), '1);
    // build a short list with duplicates
    send_request(ole_pkg::CMD_INSERT, '0, '1);
    send_request(ole_pkg::CMD_INSERT, '0, '0);
    send_request(ole_pkg::CMD_INSERT, ole_pkg::AW'(2), 64'h8000_0000_0000_0001);
    send_request(ole_pkg::CMD_INSERT, ole_pkg::AW'(1), '1);
    send_request(ole_pkg::CMD_FIND, '0, '1);
    send_request(ole_pkg::CMD_FIND, '0, '0);
    send_request(ole_pkg::CMD_FIND, '0, 64'h5);
    send_request(ole_pkg::CMD_READ, ole_pkg::AW'(3), '0);
    send_request(ole_pkg::CMD_READ, ole_pkg::AW'(4), '0);
    send_request(ole_pkg::CMD_READ, ole_pkg::AW'(ole_pkg::DEPTH - 1), '0);
    send_request(ole_pkg::CMD_REMOVE, ole_pkg::AW'(ole_pkg::DEPTH - 1), '0);
    send_request(ole_pkg::CMD_REMOVE, ole_pkg::AW'(3), '0);
    send_request(ole_pkg::CMD_REMOVE, '0, '0);
    send_request(ole_pkg::CMD_READ, '0, '0);

    // fill to capacity, then work the full list
    while (shadow.held < ole_pkg::DEPTH)
      send_request(ole_pkg::CMD_INSERT, ole_pkg::AW'($urandom_range(shadow.held)), pick_word());
    send_request(ole_pkg::CMD_INSERT, '0, '1);
    send_request(ole_pkg::CMD_INSERT, ole_pkg::AW'(ole_pkg::DEPTH - 1), '0);
    send_request(ole_pkg::CMD_READ, ole_pkg::AW'(ole_pkg::DEPTH - 1), '0);
    send_request(ole_pkg::CMD_FIND, '0, shadow.words[ole_pkg::DEPTH-1]);
    send_request(ole_pkg::CMD_REMOVE, ole_pkg::AW'(ole_pkg::DEPTH - 1), '0);
    send_request(ole_pkg::CMD_INSERT, ole_pkg::AW'(ole_pkg::DEPTH - 1), 64'h0123_4567_89ab_cdef);
    send_request(ole_pkg::CMD_REMOVE, '0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = (ph == 1) ? 50 : (ph == 3) ? 15 : 0;
      rx_stall_pct = (ph == 2) ? 50 : (ph == 3) ? 15 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 150) hold_req = 1'b1;
        random_request((n / 60) % 3, cmd, pos, data);
        send_request(cmd, pos, data);
      end
    end

    in_valid_i <= 1'b0;
    while (shadow.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    $display("Checked %0d of %0d requests: read %0d, insert %0d, remove %0d, find %0d",
             shadow.checked, shadow.requests, shadow.per_cmd[ole_pkg::CMD_READ],
             shadow.per_cmd[ole_pkg::CMD_INSERT], shadow.per_cmd[ole_pkg::CMD_REMOVE],
             shadow.per_cmd[ole_pkg::CMD_FIND]);
    $display("Status ok %0d, full %0d, out of range %0d; find hits %0d; longest list %0d",
             shadow.per_status[ole_pkg::ST_OK], shadow.per_status[ole_pkg::ST_FULL],
             shadow.per_status[ole_pkg::ST_RANGE], shadow.find_hits, shadow.max_held);
    if (shadow.errors == 0 && shadow.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
